>>> rtl/stf_pkg.sv
// ============================================================================
// stf_pkg: shared types and constants of the similarity transform fit
// Holds field widths, command and status structs between controller and
// datapath, and the table of product terms used by the closed-form solve.
// ============================================================================
package stf_pkg;

    // Field and accumulator widths.
    localparam int MAX_PAIRS_DEF = 65536;
    localparam int IN_W          = 16;
    localparam int SUM_W         = 32;
    localparam int NORM_W        = 48;
    localparam int XSUM_W        = 49;
    localparam int VAL_W         = 32;
    localparam int FRAC_W        = 16;
    localparam int MIN_POINTS    = 2;

    // Shared serial multiplier and divider widths.
    localparam int MUL_A_W = 49;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int NUM_W   = 84;
    localparam int DEN_W   = 64;

    // Solve sequence.
    localparam int TERM_W    = 4;
    localparam int TERM_LAST = 12;

    typedef enum logic [1:0] {ST_OK, ST_FEW, ST_DEGEN, ST_SAT} t_status;
    typedef enum logic [1:0] {PROD_NONE, PROD_NORM, PROD_DOT, PROD_CROSS} t_prod;
    typedef enum logic [2:0] {A_NORM, A_DOT, A_CROSS, A_SX, A_SY} t_asel;
    typedef enum logic [2:0] {B_N, B_SX, B_SY, B_DX, B_DY, B_C, B_S} t_bsel;
    typedef enum logic [1:0] {INIT_KEEP, INIT_ZERO, INIT_DX, INIT_DY} t_init;
    typedef enum logic [2:0] {DEST_NONE, DEST_D, DEST_C, DEST_S, DEST_TX, DEST_TY} t_dest;

    // One product term of the solve; a destination other than none ends a group.
    typedef struct packed {
        t_asel a_sel;
        t_bsel b_sel;
        logic  sub;
        t_init init;
        t_dest dest;
    } t_term;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    acc_load;
        t_prod   prod;
        logic    clear_res;
        logic    mul_start;
        logic    t_acc;
        t_term   term;
        logic    d_latch;
        logic    div_start;
        logic    div_store;
        logic    emit;
        t_status emit_status;
        logic    clear_sums;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
        logic few_points;
        logic d_zero;
        logic mul_done;
        logic div_done;
        logic div_sat;
        logic out_busy;
    } t_dp_stat;

    // Term table: D, then the numerators of c and s, then those of tx and ty.
    function automatic t_term term_info(input logic [TERM_W-1:0] idx);
        t_term t;
        t.a_sel = A_SX;
        t.b_sel = B_N;
        t.sub   = 1'b0;
        t.init  = INIT_KEEP;
        t.dest  = DEST_NONE;
        unique case (idx)
            4'd0: begin
                t.a_sel = A_NORM; t.b_sel = B_N;  t.init = INIT_ZERO;
            end
            4'd1: begin
                t.a_sel = A_SX;   t.b_sel = B_SX; t.sub = 1'b1;
            end
            4'd2: begin
                t.a_sel = A_SY;   t.b_sel = B_SY; t.sub = 1'b1; t.dest = DEST_D;
            end
            4'd3: begin
                t.a_sel = A_DOT;  t.b_sel = B_N;  t.init = INIT_ZERO;
            end
            4'd4: begin
                t.a_sel = A_SX;   t.b_sel = B_DX; t.sub = 1'b1;
            end
            4'd5: begin
                t.a_sel = A_SY;   t.b_sel = B_DY; t.sub = 1'b1; t.dest = DEST_C;
            end
            4'd6: begin
                t.a_sel = A_CROSS; t.b_sel = B_N; t.init = INIT_ZERO;
            end
            4'd7: begin
                t.a_sel = A_SY;   t.b_sel = B_DX;
            end
            4'd8: begin
                t.a_sel = A_SX;   t.b_sel = B_DY; t.sub = 1'b1; t.dest = DEST_S;
            end
            4'd9: begin
                t.a_sel = A_SX;   t.b_sel = B_C;  t.sub = 1'b1; t.init = INIT_DX;
            end
            4'd10: begin
                t.a_sel = A_SY;   t.b_sel = B_S;  t.dest = DEST_TX;
            end
            4'd11: begin
                t.a_sel = A_SY;   t.b_sel = B_C;  t.sub = 1'b1; t.init = INIT_DY;
            end
            4'd12: begin
                t.a_sel = A_SX;   t.b_sel = B_S;  t.sub = 1'b1; t.dest = DEST_TY;
            end
            default: begin
                t.dest = DEST_NONE;
            end
        endcase
        return t;
    endfunction

endpackage

>>> rtl/similarity_transform_fit.sv
// ============================================================================
// similarity_transform_fit: least-squares 2-D similarity transform fit
// Accumulates point-pair sums and solves for scale*cos and scale*sin in
// Q16.16 and the translation in Q20.12 on the pair marked last.
// ============================================================================
// Each accepted pair is summed in steps: the transfer cycle adds the plain
// sums and the product states PROD1, PROD2 and PROD3 add the squared, dot
// and cross sums through two 16x16 multipliers. A pair marked last then
// starts the solve, which runs 13 products on a bit-serial 49x33 multiplier
// and 4 divisions on a one-bit-per-cycle 84-bit restoring divider; no pair
// is taken during it. The result sits in an output register, so the next
// set can start while it waits to be taken; a further result holds until
// that register is free. Fewer than two pairs or a zero determinant give
// zero values with status 1 or 2; any clamped value gives status 3. All
// sums clear after each result.
module similarity_transform_fit #(
    parameter int MAX_PAIRS = stf_pkg::MAX_PAIRS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [stf_pkg::IN_W-1:0]     i_src_x,
    input  logic signed [stf_pkg::IN_W-1:0]     i_src_y,
    input  logic signed [stf_pkg::IN_W-1:0]     i_dst_x,
    input  logic signed [stf_pkg::IN_W-1:0]     i_dst_y,
    input  logic                                i_last_pair,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [stf_pkg::VAL_W-1:0]    o_scaled_cos,
    output logic signed [stf_pkg::VAL_W-1:0]    o_scaled_sin,
    output logic signed [stf_pkg::VAL_W-1:0]    o_shift_x,
    output logic signed [stf_pkg::VAL_W-1:0]    o_shift_y,
    output logic [1:0]                          o_status
);
    import stf_pkg::*;

    t_cmd     n_cmd;
    t_dp_stat n_stat;

    // Sequencer.
    stf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (n_stat),
        .o_cmd      (n_cmd)
    );

    // Sums, shared arithmetic and result register.
    stf_datapath #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (n_cmd),
        .o_stat       (n_stat),
        .i_src_x      (i_src_x),
        .i_src_y      (i_src_y),
        .i_dst_x      (i_dst_x),
        .i_dst_y      (i_dst_y),
        .i_last_pair  (i_last_pair),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_scaled_cos (o_scaled_cos),
        .o_scaled_sin (o_scaled_sin),
        .o_shift_x    (o_shift_x),
        .o_shift_y    (o_shift_y),
        .o_status     (o_status)
    );

endmodule

>>> rtl/stf_mul.sv
// ============================================================================
// stf_mul: shared radix-2 signed multiplier
// Multiplies a 49-bit signed operand by a 33-bit signed operand, one
// multiplier bit per cycle; the top bit carries negative weight.
// ============================================================================
module stf_mul (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [stf_pkg::MUL_A_W-1:0]    i_a,
    input  logic signed [stf_pkg::MUL_B_W-1:0]    i_b,
    output logic signed [stf_pkg::MUL_P_W-1:0]    o_p,
    output logic                                  o_done
);
    import stf_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W);

    logic                     r_busy;
    logic                     r_done;
    logic [CNT_W-1:0]         r_cnt;
    logic [MUL_P_W-1:0]       r_a;
    logic [MUL_B_W-1:0]       r_b;
    logic [MUL_P_W-1:0]       r_p;
    logic                     n_top;

    assign n_top = (r_cnt == CNT_W'(MUL_B_W - 1));

    // Control: busy for one cycle per multiplier bit, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (n_top) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift-and-add datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= {{(MUL_P_W - MUL_A_W){i_a[MUL_A_W-1]}}, i_a};
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_p <= n_top ? (r_p - r_a) : (r_p + r_a);
            end
            r_a <= {r_a[MUL_P_W-2:0], 1'b0};
            r_b <= {1'b0, r_b[MUL_B_W-1:1]};
        end
    end

    assign o_p    = r_p;
    assign o_done = r_done;

endmodule

>>> rtl/stf_div.sv
// ============================================================================
// stf_div: shared restoring divider with rounding and saturation
// Divides a signed 84-bit numerator by a positive 64-bit divisor, one
// quotient bit per cycle, rounds to nearest with ties away from zero and
// clamps the result to the 32-bit signed range.
// ============================================================================
module stf_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [stf_pkg::NUM_W-1:0]           i_num,
    input  logic [stf_pkg::DEN_W-1:0]           i_den,
    output logic signed [stf_pkg::VAL_W-1:0]    o_quo,
    output logic                                o_sat,
    output logic                                o_done
);
    import stf_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic                r_busy;
    logic                r_fin;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_neg;
    logic [NUM_W-1:0]    r_mag;
    logic [DEN_W-1:0]    r_rem;
    logic [DEN_W-1:0]    r_den;
    logic [NUM_W-1:0]    r_q;
    logic [VAL_W-1:0]    r_quo;
    logic                r_sat;

    logic [DEN_W:0]      n_trial;
    logic                n_ge;
    logic                n_up;
    logic [NUM_W:0]      n_qr;
    logic [NUM_W:0]      n_limit;
    logic                n_over;
    logic [VAL_W-1:0]    n_qm;

    // One restoring step: shift in the next numerator bit and try a subtract.
    assign n_trial = {r_rem, r_mag[NUM_W-1]};
    assign n_ge    = (n_trial >= {1'b0, r_den});

    // Rounding and clamping of the finished magnitude.
    assign n_up    = ({r_rem, 1'b0} >= {1'b0, r_den});
    assign n_qr    = {1'b0, r_q} + {{NUM_W{1'b0}}, n_up};
    assign n_limit = r_neg ? ((NUM_W+1)'(1) << (VAL_W - 1))
                           : (((NUM_W+1)'(1) << (VAL_W - 1)) - 1'b1);
    assign n_over  = (n_qr > n_limit);
    assign n_qm    = n_over ? n_limit[VAL_W-1:0] : n_qr[VAL_W-1:0];

    // Control sequence: start, one cycle per bit, then a finishing step that rounds and clamps before the done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NUM_W-1];
            r_mag <= i_num[NUM_W-1] ? (~i_num + 1'b1) : i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_ge ? DEN_W'(n_trial - {1'b0, r_den}) : n_trial[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], n_ge};
            r_mag <= {r_mag[NUM_W-2:0], 1'b0};
        end else if (r_fin) begin
            r_quo <= r_neg ? (~n_qm + 1'b1) : n_qm;
            r_sat <= n_over;
        end
    end

    assign o_quo  = r_quo;
    assign o_sat  = r_sat;
    assign o_done = r_done;

endmodule

>>> rtl/stf_datapath.sv
// ============================================================================
// stf_datapath: accumulators, solve registers and result register
// Accumulates the point sums with two 16x16 multipliers, holds the running
// solve value, drives the shared multiplier and divider and keeps the
// result register that faces the output channel.
// ============================================================================
module stf_datapath #(
    parameter int MAX_PAIRS = stf_pkg::MAX_PAIRS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  stf_pkg::t_cmd                        i_cmd,
    output stf_pkg::t_dp_stat                    o_stat,
    input  logic signed [stf_pkg::IN_W-1:0]      i_src_x,
    input  logic signed [stf_pkg::IN_W-1:0]      i_src_y,
    input  logic signed [stf_pkg::IN_W-1:0]      i_dst_x,
    input  logic signed [stf_pkg::IN_W-1:0]      i_dst_y,
    input  logic                                 i_last_pair,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic signed [stf_pkg::VAL_W-1:0]     o_scaled_cos,
    output logic signed [stf_pkg::VAL_W-1:0]     o_scaled_sin,
    output logic signed [stf_pkg::VAL_W-1:0]     o_shift_x,
    output logic signed [stf_pkg::VAL_W-1:0]     o_shift_y,
    output logic [1:0]                           o_status
);
    import stf_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAIRS + 1);

    // Latched input pair.
    logic [IN_W-1:0]     r_sx, r_sy, r_dx, r_dy;
    logic                r_last;
    logic                r_acc_en;

    // Running sums.
    logic [CNT_W-1:0]    r_count;
    logic [SUM_W-1:0]    r_sum_sx, r_sum_sy, r_sum_dx, r_sum_dy;
    logic [NORM_W-1:0]   r_norm;
    logic [XSUM_W-1:0]   r_dot, r_cross;

    // Solve registers.
    logic [NUM_W-1:0]    r_t;
    logic [DEN_W-1:0]    r_den;
    logic [VAL_W-1:0]    r_c, r_s, r_tx, r_ty;

    // Result register.
    logic                r_out_valid;
    logic [VAL_W-1:0]    r_o_c, r_o_s, r_o_tx, r_o_ty;
    logic [1:0]          r_o_status;

    // Pair product signals.
    logic signed [IN_W-1:0]    n_m0_b, n_m1_b;
    logic signed [2*IN_W-1:0]  n_m0, n_m1;
    logic [2*IN_W:0]           n_psum;

    // Shared unit signals.
    logic [MUL_A_W-1:0]  n_mul_a;
    logic [MUL_B_W-1:0]  n_mul_b;
    logic [MUL_P_W-1:0]  n_mul_p;
    logic                n_mul_done;
    logic [NUM_W-1:0]    n_prod;
    logic [NUM_W-1:0]    n_div_num;
    logic [DEN_W-1:0]    n_div_den;
    logic [VAL_W-1:0]    n_div_q;
    logic                n_div_sat;
    logic                n_div_done;
    logic                n_c_or_s;

    // Two pair multipliers; the operands follow the product step.
    always_comb begin
        case (i_cmd.prod)
            PROD_NORM: begin
                n_m0_b = r_sx;
                n_m1_b = r_sy;
            end
            PROD_DOT: begin
                n_m0_b = r_dx;
                n_m1_b = r_dy;
            end
            default: begin
                n_m0_b = r_dy;
                n_m1_b = r_dx;
            end
        endcase
    end
    assign n_m0   = $signed(r_sx) * n_m0_b;
    assign n_m1   = $signed(r_sy) * n_m1_b;
    assign n_psum = (i_cmd.prod == PROD_CROSS) ?
                    ({n_m0[2*IN_W-1], n_m0} - {n_m1[2*IN_W-1], n_m1}) :
                    ({n_m0[2*IN_W-1], n_m0} + {n_m1[2*IN_W-1], n_m1});

    // Accumulation of one pair, then clearing after each solve.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_sums) begin
            r_count  <= '0;
            r_sum_sx <= '0;
            r_sum_sy <= '0;
            r_sum_dx <= '0;
            r_sum_dy <= '0;
            r_norm   <= '0;
            r_dot    <= '0;
            r_cross  <= '0;
        end else if (i_cmd.acc_load) begin
            if (r_count < CNT_W'(MAX_PAIRS)) begin
                r_count  <= r_count + 1'b1;
                r_sum_sx <= r_sum_sx + {{(SUM_W-IN_W){i_src_x[IN_W-1]}}, i_src_x};
                r_sum_sy <= r_sum_sy + {{(SUM_W-IN_W){i_src_y[IN_W-1]}}, i_src_y};
                r_sum_dx <= r_sum_dx + {{(SUM_W-IN_W){i_dst_x[IN_W-1]}}, i_dst_x};
                r_sum_dy <= r_sum_dy + {{(SUM_W-IN_W){i_dst_y[IN_W-1]}}, i_dst_y};
            end
        end else if (r_acc_en) begin
            case (i_cmd.prod)
                PROD_NORM:  r_norm  <= r_norm + {{(NORM_W-2*IN_W-1){1'b0}}, n_psum};
                PROD_DOT:   r_dot   <= r_dot + {{(XSUM_W-2*IN_W-1){n_psum[2*IN_W]}}, n_psum};
                PROD_CROSS: r_cross <= r_cross + {{(XSUM_W-2*IN_W-1){n_psum[2*IN_W]}}, n_psum};
                default:    r_norm  <= r_norm;
            endcase
        end
    end

    // Input pair latch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_load) begin
            r_sx     <= i_src_x;
            r_sy     <= i_src_y;
            r_dx     <= i_dst_x;
            r_dy     <= i_dst_y;
            r_last   <= i_last_pair;
            r_acc_en <= (r_count < CNT_W'(MAX_PAIRS));
        end
    end

    // Multiplier operand selection.
    always_comb begin
        case (i_cmd.term.a_sel)
            A_NORM:  n_mul_a = {1'b0, r_norm};
            A_DOT:   n_mul_a = r_dot;
            A_CROSS: n_mul_a = r_cross;
            A_SY:    n_mul_a = {{(MUL_A_W-SUM_W){r_sum_sy[SUM_W-1]}}, r_sum_sy};
            default: n_mul_a = {{(MUL_A_W-SUM_W){r_sum_sx[SUM_W-1]}}, r_sum_sx};
        endcase
        case (i_cmd.term.b_sel)
            B_SX:    n_mul_b = {r_sum_sx[SUM_W-1], r_sum_sx};
            B_SY:    n_mul_b = {r_sum_sy[SUM_W-1], r_sum_sy};
            B_DX:    n_mul_b = {r_sum_dx[SUM_W-1], r_sum_dx};
            B_DY:    n_mul_b = {r_sum_dy[SUM_W-1], r_sum_dy};
            B_C:     n_mul_b = {r_c[VAL_W-1], r_c};
            B_S:     n_mul_b = {r_s[VAL_W-1], r_s};
            default: n_mul_b = {{(MUL_B_W-CNT_W){1'b0}}, r_count};
        endcase
    end

    stf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (n_mul_a),
        .i_b     (n_mul_b),
        .o_p     (n_mul_p),
        .o_done  (n_mul_done)
    );

    assign n_prod = {{(NUM_W-MUL_P_W){n_mul_p[MUL_P_W-1]}}, n_mul_p};

    // Running solve value: preset at the first term, then add or subtract.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            case (i_cmd.term.init)
                INIT_ZERO: r_t <= '0;
                INIT_DX:   r_t <= {{(NUM_W-SUM_W-FRAC_W){r_sum_dx[SUM_W-1]}},
                                   r_sum_dx, {FRAC_W{1'b0}}};
                INIT_DY:   r_t <= {{(NUM_W-SUM_W-FRAC_W){r_sum_dy[SUM_W-1]}},
                                   r_sum_dy, {FRAC_W{1'b0}}};
                default:   r_t <= r_t;
            endcase
        end else if (i_cmd.t_acc) begin
            r_t <= i_cmd.term.sub ? (r_t - n_prod) : (r_t + n_prod);
        end
        if (i_cmd.d_latch) begin
            r_den <= r_t[DEN_W-1:0];
        end
    end

    // Divider operands: c and s divide by D in Q16.16, tx and ty by 16 n.
    assign n_c_or_s  = (i_cmd.term.dest == DEST_C) || (i_cmd.term.dest == DEST_S);
    assign n_div_num = n_c_or_s ? {r_t[NUM_W-FRAC_W-1:0], {FRAC_W{1'b0}}} : r_t;
    assign n_div_den = n_c_or_s ? r_den : {{(DEN_W-CNT_W-4){1'b0}}, r_count, 4'b0000};

    stf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (n_div_num),
        .i_den   (n_div_den),
        .o_quo   (n_div_q),
        .o_sat   (n_div_sat),
        .o_done  (n_div_done)
    );

    // Solved values; cleared at the start of each solve.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_res) begin
            r_c  <= '0;
            r_s  <= '0;
            r_tx <= '0;
            r_ty <= '0;
        end else if (i_cmd.div_store) begin
            case (i_cmd.term.dest)
                DEST_C:  r_c  <= n_div_q;
                DEST_S:  r_s  <= n_div_q;
                DEST_TX: r_tx <= n_div_q;
                DEST_TY: r_ty <= n_div_q;
                default: r_c  <= r_c;
            endcase
        end
    end

    // Result register: holds while stalled, loads on emit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_c      <= r_c;
            r_o_s      <= r_s;
            r_o_tx     <= r_tx;
            r_o_ty     <= r_ty;
            r_o_status <= i_cmd.emit_status;
        end
    end

    // Status back to the controller.
    assign o_stat.last       = r_last;
    assign o_stat.few_points = (r_count < CNT_W'(MIN_POINTS));
    assign o_stat.d_zero     = (r_t[DEN_W-1:0] == '0);
    assign o_stat.mul_done   = n_mul_done;
    assign o_stat.div_done   = n_div_done;
    assign o_stat.div_sat    = n_div_sat;
    assign o_stat.out_busy   = r_out_valid && i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_scaled_cos = r_o_c;
    assign o_scaled_sin = r_o_s;
    assign o_shift_x    = r_o_tx;
    assign o_shift_y    = r_o_ty;
    assign o_status     = r_o_status;

endmodule

>>> rtl/stf_ctrl.sv
// ============================================================================
// stf_ctrl: sequencing state machine of the similarity transform fit
// Steps each accepted pair through the product states PROD1 to PROD3 and, on
// the last pair, walks the term table through the shared multiplier and divider.
// ============================================================================
module stf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  stf_pkg::t_dp_stat    i_stat,
    output stf_pkg::t_cmd        o_cmd
);
    import stf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PROD1, S_PROD2, S_PROD3, S_CHECK, S_MUL, S_MUL_WAIT,
        S_DZ, S_DIV, S_DIV_WAIT, S_EMIT
    } t_state;

    t_state              r_state;
    logic [TERM_W-1:0]   r_term;
    logic                r_sat;
    t_status             r_status;
    t_term               n_term;

    assign n_term = term_info(r_term);

    // State, term index and result status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_term   <= '0;
            r_sat    <= 1'b0;
            r_status <= ST_OK;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_PROD1;
                end
                S_PROD1: r_state <= S_PROD2;
                S_PROD2: r_state <= S_PROD3;
                S_PROD3: r_state <= i_stat.last ? S_CHECK : S_IDLE;
                S_CHECK: begin
                    r_term <= '0;
                    r_sat  <= 1'b0;
                    if (i_stat.few_points) begin
                        r_status <= ST_FEW;
                        r_state  <= S_EMIT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_MUL_WAIT;
                S_MUL_WAIT: begin
                    if (i_stat.mul_done) begin
                        if (n_term.dest == DEST_NONE) begin
                            r_term  <= r_term + 1'b1;
                            r_state <= S_MUL;
                        end else if (n_term.dest == DEST_D) begin
                            r_state <= S_DZ;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DZ: begin
                    if (i_stat.d_zero) begin
                        r_status <= ST_DEGEN;
                        r_state  <= S_EMIT;
                    end else begin
                        r_term  <= r_term + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_DIV: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (i_stat.div_done) begin
                        r_sat <= r_sat | i_stat.div_sat;
                        if (r_term == TERM_W'(TERM_LAST)) begin
                            r_status <= (r_sat || i_stat.div_sat) ? ST_SAT : ST_OK;
                            r_state  <= S_EMIT;
                        end else begin
                            r_term  <= r_term + 1'b1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_EMIT: begin
                    if (!i_stat.out_busy) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Commands decoded from the state.
    always_comb begin
        o_cmd             = '0;
        o_cmd.term        = n_term;
        o_cmd.emit_status = r_status;
        unique case (r_state)
            S_IDLE:     o_cmd.acc_load  = i_in_valid;
            S_PROD1:    o_cmd.prod      = PROD_NORM;
            S_PROD2:    o_cmd.prod      = PROD_DOT;
            S_PROD3:    o_cmd.prod      = PROD_CROSS;
            S_CHECK:    o_cmd.clear_res = 1'b1;
            S_MUL:      o_cmd.mul_start = 1'b1;
            S_MUL_WAIT: o_cmd.t_acc     = i_stat.mul_done;
            S_DZ:       o_cmd.d_latch   = 1'b1;
            S_DIV:      o_cmd.div_start = 1'b1;
            S_DIV_WAIT: o_cmd.div_store = i_stat.div_done;
            S_EMIT: begin
                o_cmd.emit       = !i_stat.out_busy;
                o_cmd.clear_sums = !i_stat.out_busy;
            end
            default:    o_cmd.acc_load  = 1'b0;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> rtl/stf_checker.sv
// ============================================================================
// stf_checker: port-level checks of the similarity transform fit
// Watches both channels of the top level and is bound to it below.
// ============================================================================
module stf_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  logic signed [stf_pkg::IN_W-1:0]     i_src_x,
    input  logic signed [stf_pkg::IN_W-1:0]     i_src_y,
    input  logic signed [stf_pkg::IN_W-1:0]     i_dst_x,
    input  logic signed [stf_pkg::IN_W-1:0]     i_dst_y,
    input  logic                                i_last_pair,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [stf_pkg::VAL_W-1:0]    o_scaled_cos,
    input  logic signed [stf_pkg::VAL_W-1:0]    o_scaled_sin,
    input  logic signed [stf_pkg::VAL_W-1:0]    o_shift_x,
    input  logic signed [stf_pkg::VAL_W-1:0]    o_shift_y,
    input  logic [1:0]                          o_status
);
    import stf_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its values.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
        $stable(o_scaled_cos) && $stable(o_scaled_sin) && $stable(o_shift_x)
        && $stable(o_shift_y) && $stable(o_status))
        else $error("stalled result changed");

    // Too few pairs or a degenerate set report all-zero values.
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FEW || o_status == ST_DEGEN) |->
        o_scaled_cos == '0 && o_scaled_sin == '0 && o_shift_x == '0
        && o_shift_y == '0)
        else $error("flagged result carries nonzero values");

    // A transfer on the input is followed by the product cycles.
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a transfer");

endmodule

bind similarity_transform_fit stf_checker u_stf_checker (.*);

>>> bench/tb_similarity_transform_fit.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_similarity_transform_fit: testbench of the similarity transform fit
// Drives point-pair transfers with random gaps and output stalls, predicts
// each fitted transform with an independent wide-integer solver and compares
// every result field against the oldest pending prediction.
// ============================================================================
module tb_similarity_transform_fit;
    import stf_pkg::*;

    localparam int  FULL_SET   = MAX_PAIRS_DEF;
    localparam int  DRAIN_WAIT = 2000;
    localparam longint CYCLE_LIMIT = 10000000;

    typedef struct {
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
        logic signed [31:0] tx_v;
        logic signed [31:0] ty_v;
        t_status            status;
    } t_fit;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    logic signed [15:0] i_src_x, i_src_y, i_dst_x, i_dst_y;
    logic i_last_pair;
    logic o_out_valid;
    logic i_out_stall;
    logic signed [31:0] o_scaled_cos, o_scaled_sin, o_shift_x, o_shift_y;
    logic [1:0] o_status;

    // Predictor state: running sums of the current point set.
    longint pair_cnt, sum_sx, sum_sy, sum_dx, sum_dy, sum_norm, sum_dot, sum_cross;
    t_fit   expected_fits[$];
    int     send_idle_pct, recv_idle_pct;
    int     error_count;
    longint cycle_count;

    similarity_transform_fit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_src_x      (i_src_x),
        .i_src_y      (i_src_y),
        .i_dst_x      (i_dst_x),
        .i_dst_y      (i_dst_y),
        .i_last_pair  (i_last_pair),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_scaled_cos (o_scaled_cos),
        .o_scaled_sin (o_scaled_sin),
        .o_shift_x    (o_shift_x),
        .o_shift_y    (o_shift_y),
        .o_status     (o_status)
    );

    // Clock generation.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Rounded division, ties away from zero, clamped to 32 bits signed.
    function automatic logic signed [31:0] div_round_clamp(
        input logic signed [127:0] num, input logic [127:0] den, inout bit sat);
        logic [127:0] mag, quo, rem, lim;
        logic neg;
        neg = num < 0;
        mag = neg ? -num : num;
        quo = mag / den;
        rem = mag % den;
        if ((rem << 1) >= den) quo = quo + 1;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (quo > lim) begin
            quo = lim;
            sat = 1'b1;
        end
        return neg ? -quo[31:0] : quo[31:0];
    endfunction

    task automatic clear_sums();
        pair_cnt = 0; sum_sx = 0; sum_sy = 0; sum_dx = 0; sum_dy = 0;
        sum_norm = 0; sum_dot = 0; sum_cross = 0;
    endtask

    // Accumulate one accepted pair and solve the set when it is the last.
    task automatic fit_pair(input logic signed [15:0] sx, sy, dx, dy, input logic last);
        logic signed [127:0] n, qs, xs, ys, dxs, dys, dots, crs, dd, nc, ns, cw, sw, tx, ty;
        logic [127:0] den;
        t_fit fit;
        bit sat;
        longint a, b, c, e;
        a = sx; b = sy; c = dx; e = dy;
        if (pair_cnt < FULL_SET) begin
            pair_cnt++;
            sum_sx += a; sum_sy += b; sum_dx += c; sum_dy += e;
            sum_norm += a * a + b * b;
            sum_dot += a * c + b * e;
            sum_cross += a * e - b * c;
        end
        if (!last) return;
        fit = '{0, 0, 0, 0, ST_OK};
        if (pair_cnt < MIN_POINTS) begin
            fit.status = ST_FEW;
        end else begin
            n = pair_cnt; qs = sum_norm; xs = sum_sx; ys = sum_sy;
            dxs = sum_dx; dys = sum_dy; dots = sum_dot; crs = sum_cross;
            dd = n * qs - xs * xs - ys * ys;
            if (dd[63:0] == 64'd0) begin
                fit.status = ST_DEGEN;
            end else begin
                sat = 1'b0;
                den = {64'd0, dd[63:0]};
                nc = n * dots - xs * dxs - ys * dys;
                ns = n * crs + ys * dxs - xs * dys;
                fit.cos_v = div_round_clamp(nc <<< 16, den, sat);
                fit.sin_v = div_round_clamp(ns <<< 16, den, sat);
                cw = fit.cos_v;
                sw = fit.sin_v;
                tx = (dxs <<< 16) - cw * xs + sw * ys;
                ty = (dys <<< 16) - cw * ys - sw * xs;
                fit.tx_v = div_round_clamp(tx, n * 16, sat);
                fit.ty_v = div_round_clamp(ty, n * 16, sat);
                fit.status = sat ? ST_SAT : ST_OK;
            end
        end
        expected_fits.push_back(fit);
        clear_sums();
    endtask

    // Send one pair transfer, with a random gap before it.
    task automatic send_pair(input logic signed [15:0] sx, sy, dx, dy, input logic last);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_src_x     <= sx;
        i_src_y     <= sy;
        i_dst_x     <= dx;
        i_dst_y     <= dy;
        i_last_pair <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        fit_pair(sx, sy, dx, dy, last);
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(3, 0))
            0: return 16'($urandom);
            1: return 16'($urandom_range(64, 0)) - 16'sd32;
            2: return $urandom_range(1, 0) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($urandom_range(4000, 0)) - 16'sd2000;
        endcase
    endfunction

    // Wait until every result has come back, then let the block settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_fits.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Result checker and receiver stall generation.
    always @(posedge i_clk) begin
        t_fit want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_fits.size() == 0) begin
                $error("unexpected result transfer");
                error_count++;
            end else begin
                want = expected_fits.pop_front();
                if (o_scaled_cos !== want.cos_v) begin
                    $error("scaled_cos expected %0d actual %0d", want.cos_v, o_scaled_cos);
                    error_count++;
                end
                if (o_scaled_sin !== want.sin_v) begin
                    $error("scaled_sin expected %0d actual %0d", want.sin_v, o_scaled_sin);
                    error_count++;
                end
                if (o_shift_x !== want.tx_v) begin
                    $error("shift_x expected %0d actual %0d", want.tx_v, o_shift_x);
                    error_count++;
                end
                if (o_shift_y !== want.ty_v) begin
                    $error("shift_y expected %0d actual %0d", want.ty_v, o_shift_y);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_status);
                    error_count++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end

    // Run timeout.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Field extremes, each status and a plain rotation-and-shift set.
    task automatic test_directed();
        send_pair(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b1);
        send_pair(16'sd16, 16'sd16, 16'sd5, 16'sd5, 1'b0);
        send_pair(16'sd16, 16'sd16, 16'sd5, 16'sd5, 1'b0);
        send_pair(16'sd16, 16'sd16, 16'sd5, 16'sd5, 1'b1);
        send_pair(16'sd0, 16'sd0, 16'sh8000, 16'sh8000, 1'b0);
        send_pair(16'sd1, 16'sd0, 16'sh7FFF, 16'sh7FFF, 1'b1);
        send_pair(16'sd0, 16'sd0, 16'sd100, 16'sd200, 1'b0);
        send_pair(16'sd160, 16'sd0, 16'sd100, 16'sd360, 1'b0);
        send_pair(16'sd0, 16'sd160, -16'sd60, 16'sd200, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0);
        send_pair(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 1'b0);
        send_pair(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0);
        send_pair(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1);
        send_pair(-16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b1);
        drain();
    endtask

    // Random sets: mostly small well-formed sets, some single or repeated points.
    task automatic test_random_sets(input int items);
        int sent, size, kind;
        logic signed [15:0] sx, sy, dx, dy;
        sent = 0;
        while (sent < items) begin
            kind = $urandom_range(9, 0);
            size = (kind == 0) ? 1 : $urandom_range(8, 2);
            sx = rand_coord(); sy = rand_coord(); dx = rand_coord(); dy = rand_coord();
            for (int k = 0; k < size; k++) begin
                if (kind != 1) begin
                    sx = rand_coord(); sy = rand_coord();
                    dx = rand_coord(); dy = rand_coord();
                end
                send_pair(sx, sy, dx, dy, k == size - 1);
                sent++;
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_out_stall <= 1'b0;
        i_src_x     <= '0;
        i_src_y     <= '0;
        i_dst_x     <= '0;
        i_dst_y     <= '0;
        i_last_pair <= 1'b0;
        error_count = 0;
        cycle_count = 0;
        clear_sums();
        send_idle_pct = 23;
        recv_idle_pct = 61;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_sets(612);
        send_idle_pct = 61;
        recv_idle_pct = 23;
        test_random_sets(612);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sets(612);

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0 && expected_fits.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/stf_pkg.sv
rtl/stf_mul.sv
rtl/stf_div.sv
rtl/stf_datapath.sv
rtl/stf_ctrl.sv
rtl/similarity_transform_fit.sv
rtl/stf_checker.sv
bench/tb_similarity_transform_fit.sv
